/* hdl/vrst_pkg.sv */
// package for the vertex rotate/scale/translate block
// types, constants and the cordic arctangent table; no dependencies
package vrst_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd6;

    localparam logic signed [16:0] FULL_TURN    = 17'sd46080;
    localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032875;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               first_of_solid;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_max_y;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_t;

    // atan(2^-i) in degrees, Q.16
    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] v;
        begin
            case (i)
                5'd0:  v = 22'd2949120;
                5'd1:  v = 22'd1740967;
                5'd2:  v = 22'd919879;
                5'd3:  v = 22'd466945;
                5'd4:  v = 22'd234379;
                5'd5:  v = 22'd117304;
                5'd6:  v = 22'd58666;
                5'd7:  v = 22'd29335;
                5'd8:  v = 22'd14668;
                5'd9:  v = 22'd7334;
                5'd10: v = 22'd3667;
                5'd11: v = 22'd1833;
                5'd12: v = 22'd917;
                5'd13: v = 22'd458;
                5'd14: v = 22'd229;
                5'd15: v = 22'd115;
                5'd16: v = 22'd57;
                5'd17: v = 22'd29;
                5'd18: v = 22'd14;
                5'd19: v = 22'd7;
                5'd20: v = 22'd4;
                5'd21: v = 22'd2;
                5'd22: v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

/* hdl/vrst_if.sv */
// valid/ready channel interfaces for vertices, results and config writes
// depends on vrst_pkg
interface vrst_vertex_if;
    logic              valid;
    logic              ready;
    vrst_pkg::vertex_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vrst_result_if;
    logic              valid;
    logic              ready;
    vrst_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vrst_cfg_if;
    logic           valid;
    logic           ready;
    vrst_pkg::cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/vrst_cordic.sv */
// iterative cordic: angle in degrees (7 fractional bits) to cos and sin in Q1.16
// depends on vrst_pkg
module vrst_cordic #(
    parameter int CORDIC_STEPS = vrst_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [16:0]  angle,
    output logic                busy,
    output logic signed [17:0]  cos_out,
    output logic signed [17:0]  sin_out
);
    import vrst_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    typedef enum logic [1:0] { C_IDLE, C_REDUCE, C_ITER, C_FINISH } cstate_t;

    cstate_t            state_reg;
    logic [4:0]         step_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [25:0] z_reg;
    logic signed [17:0] r_reg;
    logic               neg_reg;
    logic signed [17:0] cos_reg, sin_reg;

    // reduction into [-180,180) then folding beyond +-90
    logic signed [17:0] r0, r1, r2;
    logic               fold;
    always_comb
    begin
        r0 = 18'(angle);
        if (r0 < 0)
            r0 = r0 + 18'(FULL_TURN);
        r1 = (r0 >= HALF_TURN) ? r0 - 18'(FULL_TURN) : r0;
        fold = 1'b0;
        r2 = r1;
        if (r1 > QUARTER_TURN)
        begin
            r2 = r1 - HALF_TURN;
            fold = 1'b1;
        end
        else if (r1 < -QUARTER_TURN)
        begin
            r2 = r1 + HALF_TURN;
            fold = 1'b1;
        end
    end

    // one micro-rotation
    logic signed [33:0] dx, dy, xs, ys;
    logic signed [25:0] at;
    always_comb
    begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = 26'(signed'({1'b0, atan_entry(step_reg)}));
        xs = (z_reg >= 0) ? x_reg - dx : x_reg + dx;
        ys = (z_reg >= 0) ? y_reg + dy : y_reg - dy;
    end

    // rounding to Q1.16 with clamp
    function automatic logic signed [17:0] to_unit(input logic signed [33:0] v);
        logic signed [34:0] t;
        begin
            t = (35'(v) + 35'sd8192) >>> 14;
            if (t > 35'sd65536)
                t = 35'sd65536;
            else if (t < -35'sd65536)
                t = -35'sd65536;
            return t[17:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            r_reg     <= '0;
            cos_reg   <= 18'sd65536;
            sin_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        r_reg     <= r2;
                        neg_reg   <= fold;
                        state_reg <= C_REDUCE;
                    end
                end
                C_REDUCE:
                begin
                    x_reg     <= CORDIC_GAIN;
                    y_reg     <= '0;
                    z_reg     <= 26'(r_reg) <<< 9;
                    step_reg  <= '0;
                    state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    x_reg <= xs;
                    y_reg <= ys;
                    z_reg <= (z_reg >= 0) ? z_reg - at : z_reg + at;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(NSTEPS - 1))
                        state_reg <= C_FINISH;
                end
                C_FINISH:
                begin
                    cos_reg   <= neg_reg ? -to_unit(x_reg) : to_unit(x_reg);
                    sin_reg   <= neg_reg ? -to_unit(y_reg) : to_unit(y_reg);
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign busy    = (state_reg != C_IDLE);
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
endmodule

/* hdl/vertex_rotate_scale_translate_bbox.sv */
// top level: z rotation, per-axis scale, translation and xy bounding box
// depends on vrst_pkg, vrst_if and vrst_cordic
//
// Each vertex is transferred in, then seven products (x*cos, y*sin,
// x*sin, y*cos, rx*sx, ry*sy, z*sz) go one per cycle through a single
// shared 50x18 signed multiplier, followed by the bounding box update and
// the result on the output. The result sits in an output register and the
// next vertex is not taken until it has been transferred out.
// An angle write starts the iterative CORDIC; the config channel holds
// ready low while it runs and no vertex is taken then either.
module vertex_rotate_scale_translate_bbox #(
    parameter int CORDIC_STEPS = vrst_pkg::CORDIC_STEPS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    vrst_vertex_if.sink  vin,
    vrst_result_if.source rout,
    vrst_cfg_if.sink     cfg
);
    import vrst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_DONE, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [16:0] angle_reg;
    logic [15:0] scale_x_reg, scale_y_reg, scale_z_reg;
    logic signed [31:0] shift_x_reg, shift_y_reg, shift_z_reg;
    vertex_t  v_reg;
    result_t  res_reg;
    logic signed [31:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [67:0] acc_reg;
    logic signed [49:0] rx_reg, ry_reg;
    logic signed [31:0] ox_reg;

    logic cs_start, cs_busy;
    logic signed [17:0] cos_value, sin_value;

    vrst_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cs_start), .angle(angle_reg),
        .busy(cs_busy), .cos_out(cos_value), .sin_out(sin_value)
    );

    logic cfg_fire, start_pend_reg;
    assign cfg.ready = !cs_busy && !start_pend_reg;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign cs_start  = start_pend_reg;

    // shared multiplier operand selection
    logic signed [49:0] ma;
    logic signed [17:0] mb;
    logic signed [67:0] prod;
    always_comb
    begin
        ma = 50'(v_reg.pos_x);
        mb = cos_value;
        case (state_reg)
            S_M0: begin ma = 50'(v_reg.pos_x); mb = cos_value; end
            S_M1: begin ma = 50'(v_reg.pos_y); mb = sin_value; end
            S_M2: begin ma = 50'(v_reg.pos_x); mb = sin_value; end
            S_M3: begin ma = 50'(v_reg.pos_y); mb = cos_value; end
            S_M4: begin ma = rx_reg; mb = 18'(signed'({1'b0, scale_x_reg})); end
            S_M5: begin ma = ry_reg; mb = 18'(signed'({1'b0, scale_y_reg})); end
            S_M6: begin ma = 50'(v_reg.pos_z); mb = 18'(signed'({1'b0, scale_z_reg})); end
            default: begin ma = 50'(v_reg.pos_x); mb = cos_value; end
        endcase
        prod = 68'(ma) * 68'(mb);
    end

    // round 16 and 8 plus translate with saturation
    function automatic logic signed [49:0] rnd16(input logic signed [67:0] v);
        logic signed [67:0] t;
        begin
            t = (v + 68'sd32768) >>> 16;
            return t[49:0];
        end
    endfunction

    function automatic logic signed [31:0] fin(input logic signed [67:0] p,
                                               input logic signed [31:0] s);
        logic signed [67:0] t;
        begin
            t = ((p + 68'sd128) >>> 8) + 68'(s);
            if (t > 68'sd2147483647)
                t = 68'sd2147483647;
            else if (t < -68'sd2147483648)
                t = -68'sd2147483648;
            return t[31:0];
        end
    endfunction

    logic signed [31:0] oy_w, oz_w;
    assign oy_w = fin(prod, shift_y_reg);
    assign oz_w = fin(prod, shift_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_pend_reg <= 1'b0;
            angle_reg      <= '0;
            scale_x_reg    <= 16'd256;
            scale_y_reg    <= 16'd256;
            scale_z_reg    <= 16'd256;
            shift_x_reg    <= '0;
            shift_y_reg    <= '0;
            shift_z_reg    <= '0;
            v_reg          <= '0;
            res_reg        <= '0;
            acc_reg        <= '0;
            rx_reg         <= '0;
            ry_reg         <= '0;
            ox_reg         <= '0;
            min_x_reg      <= 32'sh7FFFFFFF;
            max_x_reg      <= 32'sh80000000;
            min_y_reg      <= 32'sh7FFFFFFF;
            max_y_reg      <= 32'sh80000000;
        end
        else
        begin
            // configuration writes
            start_pend_reg <= 1'b0;
            if (cfg_fire)
            begin
                case (cfg.data.index)
                    REG_ANGLE:
                    begin
                        angle_reg      <= cfg.data.data[16:0];
                        start_pend_reg <= 1'b1;
                    end
                    REG_SCALE_X: scale_x_reg <= cfg.data.data[15:0];
                    REG_SCALE_Y: scale_y_reg <= cfg.data.data[15:0];
                    REG_SCALE_Z: scale_z_reg <= cfg.data.data[15:0];
                    REG_SHIFT_X: shift_x_reg <= cfg.data.data;
                    REG_SHIFT_Y: shift_y_reg <= cfg.data.data;
                    REG_SHIFT_Z: shift_z_reg <= cfg.data.data;
                    default: ;
                endcase
            end
            // vertex sequencer
            case (state_reg)
                S_IDLE:
                begin
                    if (vin.valid && vin.ready)
                    begin
                        v_reg     <= vin.data;
                        state_reg <= S_M0;
                    end
                end
                S_M0: begin acc_reg <= prod; state_reg <= S_M1; end
                S_M1: begin rx_reg <= rnd16(acc_reg - prod); state_reg <= S_M2; end
                S_M2: begin acc_reg <= prod; state_reg <= S_M3; end
                S_M3: begin ry_reg <= rnd16(acc_reg + prod); state_reg <= S_M4; end
                S_M4: begin ox_reg <= fin(prod, shift_x_reg); state_reg <= S_M5; end
                S_M5:
                begin
                    res_reg.out_x <= ox_reg;
                    res_reg.out_y <= oy_w;
                    state_reg     <= S_M6;
                end
                S_M6:
                begin
                    res_reg.out_z <= oz_w;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    // bounding box update
                    if (v_reg.first_of_solid)
                    begin
                        min_x_reg <= res_reg.out_x; max_x_reg <= res_reg.out_x;
                        min_y_reg <= res_reg.out_y; max_y_reg <= res_reg.out_y;
                        res_reg.box_min_x <= res_reg.out_x;
                        res_reg.box_max_x <= res_reg.out_x;
                        res_reg.box_min_y <= res_reg.out_y;
                        res_reg.box_max_y <= res_reg.out_y;
                    end
                    else
                    begin
                        if (res_reg.out_x < min_x_reg) min_x_reg <= res_reg.out_x;
                        if (res_reg.out_x > max_x_reg) max_x_reg <= res_reg.out_x;
                        if (res_reg.out_y < min_y_reg) min_y_reg <= res_reg.out_y;
                        if (res_reg.out_y > max_y_reg) max_y_reg <= res_reg.out_y;
                        res_reg.box_min_x <= (res_reg.out_x < min_x_reg) ?
                                             res_reg.out_x : min_x_reg;
                        res_reg.box_max_x <= (res_reg.out_x > max_x_reg) ?
                                             res_reg.out_x : max_x_reg;
                        res_reg.box_min_y <= (res_reg.out_y < min_y_reg) ?
                                             res_reg.out_y : min_y_reg;
                        res_reg.box_max_y <= (res_reg.out_y > max_y_reg) ?
                                             res_reg.out_y : max_y_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (rout.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign vin.ready  = (state_reg == S_IDLE) && !cs_busy && !start_pend_reg;
    assign rout.valid = (state_reg == S_OUT);
    assign rout.data  = res_reg;
endmodule

/* hdl/vrst_checker.sv */
// port-level checker for the vertex transform block, bound to the top level
// depends on vrst_pkg
module vrst_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input vrst_pkg::result_t out_data
);
    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // no new vertex while a result is pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");

    // a transfer in leads to no result and no input ready in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid && !in_ready)
        else $error("vertex finished too early");

    // box is ordered once a result shows
    a_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.box_min_x <= out_data.box_max_x &&
                      out_data.box_min_y <= out_data.box_max_y)
        else $error("bounding box inverted");
endmodule

bind vertex_rotate_scale_translate_bbox vrst_checker u_vrst_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(vin.valid), .in_ready(vin.ready),
    .out_valid(rout.valid), .out_ready(rout.ready), .out_data(rout.data)
);
